/* rtl/fir_decimator_assert.svh */
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FIR_DECIMATOR_ASSERT_SVH
`define FIR_DECIMATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FIRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fir_decimator check failed");

// Consequent must hold in the cycle after the antecedent
`define FIRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir_decimator check failed");

`endif

/* rtl/fird_pkg.sv */
package fird_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int CIDX_W     = 8;
    localparam int REQ_W      = 2;
    localparam int DECIM_W    = 5;
    localparam int TAPS_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Arithmetic: Q1.15 x Q1.17 products, up to 255 of them summed
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + TAPS_W;
    localparam int RND_SHIFT = COEF_W - 1;

    // Register limits and reset values
    localparam int MIN_TAPS    = 9;
    localparam int DECIM_RESET = 4;
    localparam int TAPS_RESET  = 63;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_COEF   = 2'd1,
        REQ_CLEAR  = 2'd2
    } fird_req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECIM_FACTOR = 2'd0,
        CFG_TAPS_IN_USE  = 2'd1
    } fird_cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } fird_state_t;

    // Sequencer to multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } fird_mac_ctrl_t;

endpackage

/* rtl/fird_if.sv */
// Request channel: samples, coefficient writes and clears
interface fird_req_if;
    import fird_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;

    modport source (output valid, output req_type, output sample_in,
                    output coef_index, output coef_value, input ready);
    modport sink   (input valid, input req_type, input sample_in,
                    input coef_index, input coef_value, output ready);
endinterface

// Result channel: decimated output samples
interface fird_res_if;
    import fird_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

// Configuration write channel
interface fird_cfg_if;
    import fird_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/fir_decimator.sv */
// FIR decimator: Q1.15 samples enter a history ring of taps_in_use entries
// (odd, 9..255) and every decim_factor-th sample (1..16) starts one output.
// A single shared multiply-accumulate unit walks the taps, one tap per cycle,
// so a sample that completes a decimation period holds the request channel
// not ready through the tap walk, drain and finish states (longer while the
// previous result still waits); coefficient writes, clears and the other
// samples leave the request channel ready.
// The result is rounded half up, saturated and
// held in an output register, so the next request is taken while it waits.
// History is cleared at once by valid marks (no clearing pass); a clear
// request or any register write empties it and resets position and phase.
// Coefficient slots must be written before they are used.
module fir_decimator #(
    parameter int MAX_TAPS   = 256,
    parameter int MAX_FACTOR = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    fird_req_if.sink   req,
    fird_res_if.source res,
    fird_cfg_if.sink   cfg
);
    import fird_pkg::*;

    // The ring never holds more than 255 taps, so storage stops at 256
    localparam int DEPTH  = (MAX_TAPS < 256) ? MAX_TAPS : 256;
    localparam int AW     = $clog2(DEPTH);
    localparam int TCNT_W = $clog2(DEPTH + 1);
    localparam int TOP    = (MAX_TAPS - 1) | 1;
    localparam int FW     = $clog2(MAX_FACTOR + 1);
    localparam int CW     = (FW > DECIM_W) ? FW : DECIM_W;
    localparam int PW     = $clog2(MAX_FACTOR);
    localparam int RECIP  = 65536 / DEPTH;

    fird_state_t          state_reg, state_next;
    logic [DECIM_W-1:0]   decim_reg, decim_next;
    logic [TAPS_W-1:0]    taps_reg, taps_next;
    logic [AW-1:0]        wpos_reg, wpos_next;
    logic [PW-1:0]        phase_reg, phase_next;
    logic [TCNT_W-1:0]    tap_cnt_reg, tap_cnt_next;
    logic [AW-1:0]        hpos_reg, hpos_next;
    logic                 rd_valid_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_data_reg;

    logic                 req_fire;
    logic                 cfg_fire;
    logic                 out_load;
    logic                 hist_clear;
    logic                 hist_we;
    logic                 coef_we;
    fird_mac_ctrl_t       mac_ctrl;
    logic                 mac_busy;
    logic signed [SAMPLE_W-1:0] mac_result;
    logic signed [SAMPLE_W-1:0] hist_rdata;
    logic signed [COEF_W-1:0]   coef_rdata;

    logic [10:0]          taps_odd;
    logic [TCNT_W-1:0]    eff_taps;
    logic [CW-1:0]        dec_ext;
    logic [CW-1:0]        eff_factor;
    logic [CW-1:0]        phase_inc;
    logic [AW-1:0]        wr_pos;
    logic [TCNT_W-1:0]    wr_inc;
    logic [TCNT_W-1:0]    h_inc;
    logic [20:0]          slot_prod;
    logic [8:0]           slot_q;
    logic [17:0]          slot_r;
    logic [17:0]          slot_m;
    logic [AW-1:0]        coef_slot;

    assign req_fire  = req.valid && req.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // Effective filter length: odd, at least the minimum, within storage
    always_comb
    begin
        taps_odd = {3'b000, taps_reg | TAPS_W'(1)};
        if (taps_odd < 11'(MIN_TAPS))
        begin
            eff_taps = TCNT_W'(MIN_TAPS);
        end
        else if (taps_odd > 11'(TOP))
        begin
            eff_taps = TCNT_W'(TOP);
        end
        else
        begin
            eff_taps = TCNT_W'(taps_odd);
        end
    end

    // Effective decimation factor: zero acts as one, large values saturate
    always_comb
    begin
        dec_ext = CW'(decim_reg);
        if (dec_ext == '0)
        begin
            eff_factor = CW'(1);
        end
        else if (dec_ext > CW'(MAX_FACTOR))
        begin
            eff_factor = CW'(MAX_FACTOR);
        end
        else
        begin
            eff_factor = dec_ext;
        end
    end

    // Coefficient slot: index modulo storage depth by reciprocal and one correction
    always_comb
    begin
        slot_prod = 21'(req.coef_index) * 21'(RECIP);
        slot_q    = 9'(slot_prod >> 16);
        slot_m    = 18'(slot_q) * 18'(DEPTH);
        slot_r    = 18'(req.coef_index) - slot_m;
        if (slot_r >= 18'(DEPTH))
        begin
            coef_slot = AW'(slot_r - 18'(DEPTH));
        end
        else
        begin
            coef_slot = AW'(slot_r);
        end
    end

    // Ring positions
    always_comb
    begin
        wr_pos = (TCNT_W'(wpos_reg) >= eff_taps) ? '0 : wpos_reg;
        wr_inc = TCNT_W'(wr_pos) + TCNT_W'(1);
        h_inc  = TCNT_W'(hpos_reg) + TCNT_W'(1);
        phase_inc = CW'(phase_reg) + CW'(1);
    end

    // Sequencer: next state and controls
    always_comb
    begin
        state_next   = state_reg;
        decim_next   = decim_reg;
        taps_next    = taps_reg;
        wpos_next    = wpos_reg;
        phase_next   = phase_reg;
        tap_cnt_next = tap_cnt_reg;
        hpos_next    = hpos_reg;
        hist_clear   = 1'b0;
        hist_we      = 1'b0;
        coef_we      = 1'b0;
        out_load     = 1'b0;
        mac_ctrl     = '{clear: 1'b0, valid: rd_valid_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.req_type)
                        REQ_SAMPLE:
                        begin
                            hist_we   = 1'b1;
                            wpos_next = (wr_inc == eff_taps) ? '0 : AW'(wr_inc);
                            if (phase_inc >= eff_factor)
                            begin
                                // Period complete: start the tap walk at the oldest sample
                                phase_next     = '0;
                                hpos_next      = (wr_inc == eff_taps) ? '0 : AW'(wr_inc);
                                tap_cnt_next   = '0;
                                mac_ctrl.clear = 1'b1;
                                state_next     = ST_RUN;
                            end
                            else
                            begin
                                phase_next = PW'(phase_inc);
                            end
                        end
                        REQ_COEF:
                        begin
                            coef_we = 1'b1;
                        end
                        REQ_CLEAR:
                        begin
                            hist_clear = 1'b1;
                            wpos_next  = '0;
                            phase_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // Issue one tap read per cycle
                tap_cnt_next = tap_cnt_reg + TCNT_W'(1);
                hpos_next    = (h_inc == eff_taps) ? '0 : AW'(h_inc);
                if (tap_cnt_reg == eff_taps - TCNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // Wait for the last products to reach the accumulator
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes also empty the history
        if (cfg_fire)
        begin
            case (cfg.index)
                CFG_DECIM_FACTOR:
                begin
                    decim_next = cfg.data[DECIM_W-1:0];
                    hist_clear = 1'b1;
                    wpos_next  = '0;
                    phase_next = '0;
                end
                CFG_TAPS_IN_USE:
                begin
                    taps_next  = cfg.data[TAPS_W-1:0];
                    hist_clear = 1'b1;
                    wpos_next  = '0;
                    phase_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register handshake
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            decim_reg     <= DECIM_W'(DECIM_RESET);
            taps_reg      <= TAPS_W'(TAPS_RESET);
            wpos_reg      <= '0;
            phase_reg     <= '0;
            tap_cnt_reg   <= '0;
            hpos_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            decim_reg     <= decim_next;
            taps_reg      <= taps_next;
            wpos_reg      <= wpos_next;
            phase_reg     <= phase_next;
            tap_cnt_reg   <= tap_cnt_next;
            hpos_reg      <= hpos_next;
            rd_valid_reg  <= (state_reg == ST_RUN);
            out_valid_reg <= out_valid_next;
        end
    end

    // Output data
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= mac_result;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.filtered_sample = signed'(out_data_reg);

    fird_hist_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_hist_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (hist_clear),
        .we    (hist_we),
        .waddr (wr_pos),
        .wdata (req.sample_in),
        .raddr (hpos_reg),
        .rdata (hist_rdata)
    );

    fird_coef_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_slot),
        .wdata (req.coef_value),
        .raddr (tap_cnt_reg[AW-1:0]),
        .rdata (coef_rdata)
    );

    fird_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (hist_rdata),
        .coef   (coef_rdata),
        .busy   (mac_busy),
        .result (mac_result)
    );

endmodule

/* rtl/fird_hist_ram.sv */
module fird_hist_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic                                 we,
    input  logic [AW-1:0]                        waddr,
    input  logic signed [fird_pkg::SAMPLE_W-1:0] wdata,
    input  logic [AW-1:0]                        raddr,
    output logic signed [fird_pkg::SAMPLE_W-1:0] rdata
);
    import fird_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;

    // Mark written entries, drop all marks on clear
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port with its valid mark
    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[raddr];
        rd_valid_reg <= valid_reg[raddr];
    end

    // An unmarked entry reads as zero
    assign rdata = rd_valid_reg ? signed'(rd_data_reg) : '0;

endmodule

/* rtl/fird_coef_ram.sv */
module fird_coef_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [fird_pkg::COEF_W-1:0] wdata,
    input  logic [AW-1:0]                      raddr,
    output logic signed [fird_pkg::COEF_W-1:0] rdata
);
    import fird_pkg::*;

    logic signed [COEF_W-1:0] mem [DEPTH];
    logic signed [COEF_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

/* rtl/fird_mac.sv */
module fird_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fird_pkg::fird_mac_ctrl_t             ctrl,
    input  logic signed [fird_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [fird_pkg::COEF_W-1:0]   coef,
    output logic                                 busy,
    output logic signed [fird_pkg::SAMPLE_W-1:0] result
);
    import fird_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd_q;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid && !ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(sample) * PROD_W'(coef);
    end

    // Accumulate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = prod_valid_reg;

    // Round half up from Q1.17 scaling, then saturate to the sample range
    always_comb
    begin
        rnd_sum = acc_reg + HALF;
        rnd_q   = rnd_sum >>> RND_SHIFT;
        if (rnd_q > SMAX)
        begin
            result = SMAX[SAMPLE_W-1:0];
        end
        else if (rnd_q < SMIN)
        begin
            result = SMIN[SAMPLE_W-1:0];
        end
        else
        begin
            result = rnd_q[SAMPLE_W-1:0];
        end
    end

endmodule

/* rtl/fird_checker.sv */
`include "fir_decimator_assert.svh"

module fird_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic [fird_pkg::REQ_W-1:0]  req_type,
    input logic                        res_valid,
    input logic                        res_ready
);
    import fird_pkg::*;

    // A pending result stays offered until taken
    `FIRD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

    // Coefficient writes, clears and unused codes never stall the request side
    `FIRD_ASSERT_NEXT(a_nonsample_ready, req_valid && req_ready && req_type != REQ_SAMPLE, req_ready)

    // The request side only goes busy after a sample transaction
    `FIRD_ASSERT_NOW(a_busy_cause, $fell(req_ready), $past(req_valid && req_type == REQ_SAMPLE))

    // A fresh result only appears at the end of a busy tap walk
    `FIRD_ASSERT_NOW(a_res_after_walk, $rose(res_valid), !$past(req_ready))

endmodule

bind fir_decimator fird_checker u_fird_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .res_valid (res.valid),
    .res_ready (res.ready)
);
